// File: rtl/core/broken_down_time_to_seconds_defines.svh
// assertion macros shared by the broken-down time converter
`ifndef BROKEN_DOWN_TIME_TO_SECONDS_DEFINES_SVH
`define BROKEN_DOWN_TIME_TO_SECONDS_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BDTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BDTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bdts_pkg.sv
// shared types, constants and helper functions of the broken-down time converter
`timescale 1ns / 1ps

package bdts_pkg;

    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned DAYS_TO_EPOCH = 25567;

    // one input transaction
    typedef struct packed {
        logic signed [15:0] year_offset;
        logic signed [15:0] month_index;
        logic signed [15:0] day_of_month;
        logic signed [15:0] hour_value;
        logic signed [15:0] minute_value;
        logic signed [15:0] second_value;
    } t_in;

    // month and seconds split, quotient of seconds by day length
    typedef struct packed {
        logic        [3:0]  month_rem;
        logic signed [16:0] year_adj;
        logic signed [15:0] mday;
        logic        [27:0] sec_biased;
        logic        [11:0] sec_quot;
    } t_norm;

    // final day count and second of day
    typedef struct packed {
        logic signed [24:0] days;
        logic        [16:0] sec_of_day;
        logic               reject;
    } t_days;

    // exact floor(x / 25) for x below 43690
    function automatic logic [9:0] div25(input logic [13:0] i_x);
        logic [26:0] prod;
        prod = 27'(i_x) * 27'd5243;
        return prod[26:17];
    endfunction

    // first day of month within the year
    function automatic logic [8:0] month_first_day(input logic i_leap, input logic [3:0] i_mon);
        logic [8:0] base;
        unique case (i_mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (i_leap && (i_mon >= 4'd2) && (i_mon <= 4'd11)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// File: rtl/core/bdts_if.sv
// stream interfaces of the broken-down time converter
`timescale 1ns / 1ps

interface bdts_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] year_offset;
    logic signed [15:0] month_index;
    logic signed [15:0] day_of_month;
    logic signed [15:0] hour_value;
    logic signed [15:0] minute_value;
    logic signed [15:0] second_value;

    modport source (
        output valid, year_offset, month_index, day_of_month,
               hour_value, minute_value, second_value,
        input  ready
    );
    modport sink (
        input  valid, year_offset, month_index, day_of_month,
               hour_value, minute_value, second_value,
        output ready
    );
endinterface

interface bdts_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] time_value;
    logic        [23:0] day_count;
    logic        [16:0] second_of_day;
    logic               invalid;

    modport source (
        output valid, time_value, day_count, second_of_day, invalid,
        input  ready
    );
    modport sink (
        input  valid, time_value, day_count, second_of_day, invalid,
        output ready
    );
endinterface

// File: rtl/core/bdts_norm.sv
// pipeline stages one and two: month and seconds splits by reciprocal multiply
`timescale 1ns / 1ps

module bdts_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bdts_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output bdts_pkg::t_norm o_data
);

    localparam logic signed [17:0] MON_BIAS = 18'sd32772;    // 12 * 2731
    localparam logic signed [17:0] YEAR_UNBIAS = 18'sd2731;
    localparam logic signed [28:0] SEC_BIAS = 29'sd120009600;  // 1389 days
    localparam logic [30:0] DIV3_MUL = 31'd43691;
    localparam logic [42:0] DIV675_MUL = 43'd3181458;

    logic        r_s1_valid;
    logic [12:0] r_s1_q;
    logic [16:0] r_s1_m;
    logic signed [15:0] r_s1_year;
    logic signed [15:0] r_s1_mday;
    logic [27:0] r_s1_su;

    logic        r_s2_valid;
    bdts_pkg::t_norm r_s2;

    logic w_s1_ld;
    logic w_s2_ld;

    logic signed [17:0] n_m_ext;
    logic [16:0]        n_m;
    logic [30:0]        n_mprod;
    logic signed [28:0] n_su_ext;
    logic [16:0]        n_r_full;
    logic signed [17:0] n_yr_ext;
    logic [42:0]        n_sprod;

    assign w_s2_ld = !r_s2_valid || i_ready;
    assign w_s1_ld = !r_s1_valid || w_s2_ld;
    assign o_ready = w_s1_ld;
    assign o_valid = r_s2_valid;
    assign o_data  = r_s2;

    // month biased to non-negative, then divided by 12 as (m / 4) / 3
    always_comb begin
        n_m_ext  = 18'(i_data.month_index) + MON_BIAS;
        n_m      = n_m_ext[16:0];
        n_mprod  = 31'(n_m[16:2]) * DIV3_MUL;
        n_su_ext = 29'(i_data.hour_value) * 29'sd3600 + 29'(i_data.minute_value) * 29'sd60
                 + 29'(i_data.second_value) + SEC_BIAS;
    end

    // remainder and year; seconds divided by 86400 as (s / 128) / 675
    always_comb begin
        n_r_full = r_s1_m - 17'(r_s1_q) * 17'd12;
        n_yr_ext = 18'(r_s1_year) + $signed({5'b0, r_s1_q}) - YEAR_UNBIAS;
        n_sprod  = 43'(r_s1_su[27:7]) * DIV675_MUL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_ld) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_ld) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ld) begin
            r_s1_q    <= n_mprod[29:17];
            r_s1_m    <= n_m;
            r_s1_year <= i_data.year_offset;
            r_s1_mday <= i_data.day_of_month;
            r_s1_su   <= n_su_ext[27:0];
        end
        if (w_s2_ld) begin
            r_s2.month_rem  <= n_r_full[3:0];
            r_s2.year_adj   <= n_yr_ext[16:0];
            r_s2.mday       <= r_s1_mday;
            r_s2.sec_biased <= r_s1_su;
            r_s2.sec_quot   <= n_sprod[42:31];
        end
    end

endmodule

// File: rtl/core/bdts_days.sv
// pipeline stages three to five: leap terms, day count and range check
`timescale 1ns / 1ps

module bdts_days (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bdts_pkg::t_norm i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output bdts_pkg::t_days o_data
);

    localparam logic signed [12:0] DAY_UNBIAS = 13'sd1389;
    localparam logic signed [24:0] DAYS_MIN = 25'(bdts_pkg::DAYS_TO_EPOCH - 1);

    // stage three
    logic        r_s3_valid;
    logic [15:0] r_s3_yc;
    logic        r_s3_neg;
    logic [3:0]  r_s3_mon;
    logic signed [15:0] r_s3_mday;
    logic [16:0] r_s3_rem;
    logic signed [12:0] r_s3_dq;
    logic [13:0] r_s3_y4;
    logic [9:0]  r_s3_d100;
    logic [9:0]  r_s3_d400;
    logic [9:0]  r_s3_a;
    logic [9:0]  r_s3_b;
    logic [13:0] r_s3_yq4;
    logic [11:0] r_s3_yq16;
    logic        r_s3_y4z;
    logic        r_s3_y16z;

    // stage four
    logic        r_s4_valid;
    logic signed [24:0] r_s4_base;
    logic        r_s4_leap;
    logic        r_s4_neg;
    logic [3:0]  r_s4_mon;
    logic [16:0] r_s4_rem;

    // stage five
    logic        r_s5_valid;
    bdts_pkg::t_days r_s5;

    logic w_s3_ld;
    logic w_s4_ld;
    logic w_s5_ld;

    logic        n_neg;
    logic [15:0] n_yc;
    logic [15:0] n_y;
    logic [16:0] n_y4_sum;
    logic [16:0] n_y100_sum;
    logic [16:0] n_y400_sum;
    logic [27:0] n_rem_full;
    logic        n_leap;
    logic signed [24:0] n_base;
    logic signed [24:0] n_days;

    assign w_s5_ld = !r_s5_valid || i_ready;
    assign w_s4_ld = !r_s4_valid || w_s5_ld;
    assign w_s3_ld = !r_s3_valid || w_s4_ld;
    assign o_ready = w_s3_ld;
    assign o_valid = r_s5_valid;
    assign o_data  = r_s5;

    // negative year is clamped to zero, its result is rejected later
    always_comb begin
        n_neg      = i_data.year_adj[16];
        n_yc       = n_neg ? 16'd0 : i_data.year_adj[15:0];
        n_y        = n_yc + 16'd1900;
        n_y4_sum   = 17'(n_yc) + 17'd3;
        n_y100_sum = 17'(n_yc) + 17'd99;
        n_y400_sum = 17'(n_yc) + 17'd299;
        n_rem_full = i_data.sec_biased - 28'(i_data.sec_quot) * 28'(bdts_pkg::SECS_PER_DAY);
    end

    // leap test of the calendar year and day count without month start
    always_comb begin
        n_leap = (r_s3_y4z && (14'(r_s3_a) * 14'd25 != r_s3_yq4))
              || (r_s3_y16z && (12'(r_s3_b) * 12'd25 == r_s3_yq16));
        n_base = $signed(25'(r_s3_yc) * 25'd365) + $signed(25'(r_s3_y4))
               - $signed(25'(r_s3_d100)) + $signed(25'(r_s3_d400))
               + 25'(r_s3_mday) + 25'(r_s3_dq) - 25'sd1;
    end

    always_comb begin
        n_days = r_s4_base + $signed(25'(bdts_pkg::month_first_day(r_s4_leap, r_s4_mon)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            if (w_s3_ld) begin
                r_s3_valid <= i_valid;
            end
            if (w_s4_ld) begin
                r_s4_valid <= r_s3_valid;
            end
            if (w_s5_ld) begin
                r_s5_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s3_ld) begin
            r_s3_yc   <= n_yc;
            r_s3_neg  <= n_neg;
            r_s3_mon  <= i_data.month_rem;
            r_s3_mday <= i_data.mday;
            r_s3_rem  <= n_rem_full[16:0];
            r_s3_dq   <= $signed({1'b0, i_data.sec_quot}) - DAY_UNBIAS;
            r_s3_y4   <= n_y4_sum[15:2];
            r_s3_d100 <= bdts_pkg::div25(n_y100_sum[15:2]);
            r_s3_d400 <= bdts_pkg::div25({2'b0, n_y400_sum[15:4]});
            r_s3_a    <= bdts_pkg::div25(n_y[15:2]);
            r_s3_b    <= bdts_pkg::div25({2'b0, n_y[15:4]});
            r_s3_yq4  <= n_y[15:2];
            r_s3_yq16 <= n_y[15:4];
            r_s3_y4z  <= (n_y[1:0] == 2'd0);
            r_s3_y16z <= (n_y[3:0] == 4'd0);
        end
        if (w_s4_ld) begin
            r_s4_base <= n_base;
            r_s4_leap <= n_leap;
            r_s4_neg  <= r_s3_neg;
            r_s4_mon  <= r_s3_mon;
            r_s4_rem  <= r_s3_rem;
        end
        if (w_s5_ld) begin
            r_s5.days       <= n_days;
            r_s5.sec_of_day <= r_s4_rem;
            r_s5.reject     <= r_s4_neg || (n_days < DAYS_MIN);
        end
    end

endmodule

// File: rtl/core/broken_down_time_to_seconds.sv
// Broken-down calendar time to Unix seconds converter, top level.
// Takes years since 1900, month, day, hour, minute and second, each a signed
// 16-bit value that may lie out of range, and returns the Unix time as the
// low 32 bits of the exact value, the Gregorian day count since 1900-01-01
// and the second of day. Months fold into the year and the time of day into
// the day count by floor division. A result is flagged invalid, with time
// all ones and zero day count and second of day, when the adjusted year is
// negative or the date falls before 1969-12-31. The block holds no state
// between transactions. It is a six-stage pipeline that accepts one
// transaction every cycle unless an output stall has filled every stage.
// The stages are set by the constant divisions, done as reciprocal
// multiplies (month and seconds each in a stage of its own), and by the
// final 25 x 17 bit multiply to seconds. A stall on the output side holds
// every occupied stage in place; empty stages still fill, so ready on the
// input side drops only when the whole pipeline is full.
`timescale 1ns / 1ps
`include "broken_down_time_to_seconds_defines.svh"

module broken_down_time_to_seconds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdts_in_if.sink     i_in,
    bdts_out_if.source  o_out
);

    localparam logic signed [24:0] EPOCH_DAYS = 25'(bdts_pkg::DAYS_TO_EPOCH);
    localparam logic signed [42:0] DAY_SECS = 43'(bdts_pkg::SECS_PER_DAY);

    // input transaction gathered into one word
    bdts_pkg::t_in   w_in;
    bdts_pkg::t_norm w_norm;
    bdts_pkg::t_days w_days;

    logic w_norm_valid;
    logic w_norm_ready;
    logic w_days_valid;
    logic w_days_ready;

    // output register stage
    logic               r_out_valid;
    logic signed [31:0] r_out_time;
    logic        [23:0] r_out_days;
    logic        [16:0] r_out_sod;
    logic               r_out_invalid;
    logic               w_out_ld;

    logic signed [24:0] n_day_rel;
    logic signed [42:0] n_prod;
    logic        [31:0] n_time;

    always_comb begin
        w_in.year_offset  = i_in.year_offset;
        w_in.month_index  = i_in.month_index;
        w_in.day_of_month = i_in.day_of_month;
        w_in.hour_value   = i_in.hour_value;
        w_in.minute_value = i_in.minute_value;
        w_in.second_value = i_in.second_value;
    end

    // stages one and two: month / 12 and seconds / 86400
    bdts_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_data  (w_in),
        .o_valid (w_norm_valid),
        .i_ready (w_norm_ready),
        .o_data  (w_norm)
    );

    // stages three to five: leap terms, day count, rejection
    bdts_days u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_norm_valid),
        .o_ready (w_norm_ready),
        .i_data  (w_norm),
        .o_valid (w_days_valid),
        .i_ready (w_days_ready),
        .o_data  (w_days)
    );

    // stage six: days since epoch to seconds, low 32 bits kept
    always_comb begin
        n_day_rel = w_days.days - EPOCH_DAYS;
        n_prod    = 43'(n_day_rel) * DAY_SECS;
        n_time    = n_prod[31:0] + 32'(w_days.sec_of_day);
    end

    // the output register frees as soon as its result is taken
    assign w_out_ld     = !r_out_valid || o_out.ready;
    assign w_days_ready = w_out_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ld) begin
            r_out_valid <= w_days_valid;
        end
    end

    // rejected transactions carry a fixed result pattern
    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            if (w_days.reject) begin
                r_out_time    <= -32'sd1;
                r_out_days    <= 24'd0;
                r_out_sod     <= 17'd0;
                r_out_invalid <= 1'b1;
            end else begin
                r_out_time    <= $signed(n_time);
                r_out_days    <= w_days.days[23:0];
                r_out_sod     <= w_days.sec_of_day;
                r_out_invalid <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.time_value    = r_out_time;
    assign o_out.day_count     = r_out_days;
    assign o_out.second_of_day = r_out_sod;
    assign o_out.invalid       = r_out_invalid;

    // rejected result has the fixed pattern on every field
    `BDTS_ASSERT_IMPL(a_reject_pattern, i_clk, i_rst_n, o_out.valid && o_out.invalid,
        (o_out.time_value == -32'sd1) && (o_out.day_count == 24'd0) && (o_out.second_of_day == 17'd0),
        "rejected transaction with nonzero fields")

    // accepted result lies on or after 1969-12-31 with a normalized second
    `BDTS_ASSERT_IMPL(a_valid_range, i_clk, i_rst_n, o_out.valid && !o_out.invalid,
        (o_out.second_of_day < 17'(bdts_pkg::SECS_PER_DAY))
        && (o_out.day_count >= 24'(bdts_pkg::DAYS_TO_EPOCH - 1)),
        "accepted transaction out of range")

    // a finished day count moves into a free output register
    `BDTS_ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, w_days_valid && w_out_ld, o_out.valid,
        "output register did not take a finished transaction")

    // a stalled output holds its time, day count and invalid flag
    `BDTS_ASSERT_NEXT(a_stall_time, i_clk, i_rst_n, r_out_valid && !w_out_ld,
        $stable(r_out_time) && $stable(r_out_days) && $stable(r_out_invalid),
        "output register changed during a stall")

endmodule
